[rtl/lpt_pkg.sv]
// Shared constants, types and state encoding for the LRU page tracker.
`default_nettype none

package lpt_pkg;

    // List depth and page number space
    localparam int MAX_FRAMES = 8;
    localparam int PAGE_SPACE = 16;

    // Derived widths
    localparam int PAGE_W = (PAGE_SPACE > 1) ? $clog2(PAGE_SPACE) : 1;
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    // Fixed field widths of the register and the result
    localparam int CAP_W = 4;
    localparam int OCC_W = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    typedef logic [PAGE_W-1:0] t_page;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_UPDATE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/lpt_req_if.sv]
// Page reference channel: valid/ready handshake carrying one page number.
`default_nettype none

interface lpt_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

`default_nettype wire

[rtl/lpt_rsp_if.sv]
// Result channel: valid/ready handshake carrying hit, eviction and occupancy.
`default_nettype none

interface lpt_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       evicted;
    logic [3:0] evicted_page;
    logic [3:0] occupancy;

    modport source (output valid, output hit, output evicted, output evicted_page,
                    output occupancy, input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_page,
                    input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/lpt_ctrl.sv]
// Controller: sequences capture and update of one reference and owns result valid.
`default_nettype none

module lpt_ctrl
    import lpt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  wire  i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                // take an item only if the result register is free by the next edge
                o_in_ready    = !r_out_valid || i_out_ready;
                o_cmd.capture = i_in_valid && o_in_ready;
                if (o_cmd.capture) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.update))
        else $error("capture and update issued together");

    a_capture_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.update)
        else $error("captured item not updated in the next cycle");

    a_update_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> r_out_valid)
        else $error("result not presented after update");

endmodule

`default_nettype wire

[rtl/lpt_datapath.sv]
// Datapath: recency list, resident count, capacity register and result register.
`default_nettype none

module lpt_datapath
    import lpt_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cmd             i_cmd,
    input  wire [3:0]        i_page,
    input  wire              i_cfg_we,
    input  wire [CAP_W-1:0]  i_cfg_wdata,
    output logic             o_hit,
    output logic             o_evicted,
    output logic [3:0]       o_evicted_page,
    output logic [OCC_W-1:0] o_occupancy
);

    t_page             r_list [MAX_FRAMES];
    t_page             n_list [MAX_FRAMES];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CAP_W-1:0]  r_capacity;
    t_page             r_page;

    logic              r_hit;
    logic              r_evicted;
    t_page             r_evicted_page;
    logic [OCC_W-1:0]  r_occupancy;

    logic [MAX_FRAMES-1:0] lpt_match;
    logic [IDX_W-1:0]      lpt_pos;
    logic                  lpt_hit;
    logic                  lpt_full;
    logic                  lpt_evict;
    logic [CNT_W-1:0]      lpt_eff_cap;
    logic [CNT_W-1:0]      lpt_count_m1;

    // Clamp capacity to the range one to list depth
    always_comb begin
        if (int'(r_capacity) > MAX_FRAMES) begin
            lpt_eff_cap = CNT_W'(MAX_FRAMES);
        end else if (r_capacity == '0) begin
            lpt_eff_cap = CNT_W'(1);
        end else begin
            lpt_eff_cap = CNT_W'(r_capacity);
        end
    end

    // Compare the page against every resident entry at once
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            lpt_match[i] = (CNT_W'(i) < r_count) && (r_list[i] == r_page);
        end
    end

    // Pick the most recent matching position
    always_comb begin
        lpt_pos = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (lpt_match[i]) begin
                lpt_pos = IDX_W'(i);
            end
        end
    end

    assign lpt_hit      = |lpt_match;
    assign lpt_full     = (r_count >= lpt_eff_cap);
    assign lpt_evict    = !lpt_hit && lpt_full;
    assign lpt_count_m1 = r_count - CNT_W'(1);

    // Move the page to the front and shift the entries that were ahead of it (all on a miss) back by one
    always_comb begin
        n_list[0] = r_page;
        for (int i = 1; i < MAX_FRAMES; i++) begin
            if (!lpt_hit || (IDX_W'(i) <= lpt_pos)) begin
                n_list[i] = r_list[i-1];
            end else begin
                n_list[i] = r_list[i];
            end
        end
    end

    // Grow the count only on a miss with a free frame
    assign n_count = (!lpt_hit && !lpt_full) ? r_count + CNT_W'(1) : r_count;

    // Control state: count and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            if (i_cmd.update) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // Payload: list, captured page and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= t_page'(i_page);
        end
        if (i_cmd.update) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_list[i] <= n_list[i];
            end
            r_hit          <= lpt_hit;
            r_evicted      <= lpt_evict;
            r_evicted_page <= lpt_evict ? r_list[lpt_count_m1[IDX_W-1:0]] : '0;
            r_occupancy    <= OCC_W'(n_count);
        end
    end

    assign o_hit          = r_hit;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = 4'(r_evicted_page);
    assign o_occupancy    = r_occupancy;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_FRAMES)
        else $error("resident count above list depth");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("resident count dropped outside reset");

    a_evict_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && lpt_evict) |=> r_count == $past(r_count))
        else $error("eviction changed resident count");

endmodule

`default_nettype wire

[rtl/lru_page_tracker.sv]
// Top level of the LRU page tracker: controller, datapath and channel wiring.
//
//   Channel   Dir  Handshake    Payload
//   i_req     in   valid/ready  page[3:0]
//   o_rsp     out  valid/ready  hit, evicted, evicted_page[3:0], occupancy[3:0]
//   i_cfg_*   in   write enable capacity[3:0]
//
// Each reference passes through S_IDLE, which registers the page, and S_UPDATE, in which the
// whole resident list is compared in parallel and shifted by one position.
// The next item can be taken in the cycle after the update only if the result
// is taken in that same cycle; a stalled result holds input.
// Reset clears the resident count and sets capacity to 8; list contents are not
// cleared, as only entries below the count are ever read.
`default_nettype none

module lru_page_tracker
    import lpt_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    lpt_req_if.sink           i_req,
    lpt_rsp_if.source         o_rsp,
    input  wire               i_cfg_we,
    input  wire [CAP_W-1:0]   i_cfg_wdata
);

    t_cmd lpt_cmd;

    // Sequence the reference and the result handshake
    lpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (lpt_cmd)
    );

    // Hold the recency list and build the result
    lpt_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (lpt_cmd),
        .i_page         (i_req.page),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_hit          (o_rsp.hit),
        .o_evicted      (o_rsp.evicted),
        .o_evicted_page (o_rsp.evicted_page),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule

`default_nettype wire
